### design/decoded_picture_slot_manager_macros.svh
// Assertion macros shared by the slot manager RTL.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef DECODED_PICTURE_SLOT_MANAGER_MACROS_SVH
`define DECODED_PICTURE_SLOT_MANAGER_MACROS_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define DPSM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("slot manager assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define DPSM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("slot manager assertion failed");
`else
`define DPSM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DPSM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/dpsm_pkg.sv
`default_nettype none

package dpsm_pkg;

	// Widths of the fixed fields.
	localparam int TIME_W  = 64;
	localparam int STAMP_W = 32;
	localparam int CNT_W   = 6;
	localparam int SLOT_W  = 5;
	localparam int OP_W    = 3;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_ALLOC      = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD        = 3'd1;
	localparam logic [OP_W-1:0] OP_UPDATE     = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE_REF = 3'd3;
	localparam logic [OP_W-1:0] OP_DISPLAY    = 3'd4;
	localparam logic [OP_W-1:0] OP_FLUSH      = 3'd5;

	// Counter limits and reset values.
	localparam logic [CNT_W-1:0]   CNT_MAX        = 6'd63;
	localparam logic [CNT_W-1:0]   MAX_WAIT_RESET = 6'd2;
	localparam logic [STAMP_W-1:0] STAMP_RESET    = 32'd1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan_init;
		logic exec;
		logic issue;
		logic finish;
	} dpsm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_needed;
		logic scan_last;
	} dpsm_sts_t;

endpackage

`default_nettype wire

### design/decoded_picture_slot_manager.sv
`default_nettype none

// Decoded picture slot manager. A command word is taken when start is high
// and busy is low; each command gives exactly one result word, shown on the
// result ports for a single cycle while done is high. The receiver cannot
// stall: it must take the word in that cycle. Add, update, remove-reference,
// flush, the unused op codes and a display that finds no more than max_waiting
// pictures waiting finish in the decide state. Allocate and a display that
// finds more than max_waiting pictures waiting run a scan through every slot:
// the scan reads one slot per cycle from the time and stamp memories into a
// single comparator. The next command may be accepted in the cycle
// that shows the previous result. Write max_waiting only while busy is low
// and no result is pending.

module decoded_picture_slot_manager #(
	parameter int NUM_SLOTS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               cfg_write,
	input  logic [dpsm_pkg::CNT_W-1:0]         cfg_data,
	input  logic [dpsm_pkg::OP_W-1:0]          op,
	input  logic [dpsm_pkg::SLOT_W-1:0]        surface_index,
	input  logic                               is_reference,
	input  logic                               is_field,
	input  logic signed [dpsm_pkg::TIME_W-1:0] start_time,
	input  logic signed [dpsm_pkg::TIME_W-1:0] stop_time,
	output logic                               done,
	output logic                               ok,
	output logic [dpsm_pkg::SLOT_W-1:0]        slot,
	output logic                               delivered,
	output logic signed [dpsm_pkg::TIME_W-1:0] out_start,
	output logic signed [dpsm_pkg::TIME_W-1:0] out_stop
);

	`include "decoded_picture_slot_manager_macros.svh"

	dpsm_pkg::dpsm_cmd_t cmd;
	dpsm_pkg::dpsm_sts_t sts;

	// Sequencer.
	dpsm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Slot table, scan comparator and result register.
	dpsm_datapath #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_write     (cfg_write),
		.cfg_data      (cfg_data),
		.op            (op),
		.surface_index (surface_index),
		.is_reference  (is_reference),
		.is_field      (is_field),
		.start_time    (start_time),
		.stop_time     (stop_time),
		.done          (done),
		.ok            (ok),
		.slot          (slot),
		.delivered     (delivered),
		.out_start     (out_start),
		.out_stop      (out_stop)
	);

	// A result word always appears with the sequencer back at rest.
	`DPSM_ASSERT_IMP(a_done_not_busy, clk, arst_n, done, !busy)
	// An accepted command always occupies the sequencer for the next cycle.
	`DPSM_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	// Delivery only happens for a picture that was chosen.
	`DPSM_ASSERT_IMP(a_delivered_ok, clk, arst_n, done && delivered, ok)
	// A delivered picture never carries a negative start time.
	`DPSM_ASSERT_IMP(a_delivered_start, clk, arst_n, done && delivered, !out_start[63])

endmodule

`default_nettype wire

### design/dpsm_ctrl.sv
`default_nettype none

module dpsm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  dpsm_pkg::dpsm_sts_t sts,
	output dpsm_pkg::dpsm_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t state_q;

	// Sequencer: single-slot operations finish in the decide state, scans run
	// through every slot, wait in the drain state for the last compare, then finish.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (sts.scan_needed) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (sts.scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command decode.
	assign busy          = (state_q != ST_IDLE);
	assign cmd.load      = (state_q == ST_IDLE) && start;
	assign cmd.scan_init = (state_q == ST_DECIDE) && sts.scan_needed;
	assign cmd.exec      = (state_q == ST_DECIDE) && !sts.scan_needed;
	assign cmd.issue     = (state_q == ST_SCAN);
	assign cmd.finish    = (state_q == ST_FINISH);

endmodule

`default_nettype wire

### design/dpsm_datapath.sv
`default_nettype none

module dpsm_datapath #(
	parameter int NUM_SLOTS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dpsm_pkg::dpsm_cmd_t                cmd,
	output dpsm_pkg::dpsm_sts_t                sts,
	input  logic                               cfg_write,
	input  logic [dpsm_pkg::CNT_W-1:0]         cfg_data,
	input  logic [dpsm_pkg::OP_W-1:0]          op,
	input  logic [dpsm_pkg::SLOT_W-1:0]        surface_index,
	input  logic                               is_reference,
	input  logic                               is_field,
	input  logic signed [dpsm_pkg::TIME_W-1:0] start_time,
	input  logic signed [dpsm_pkg::TIME_W-1:0] stop_time,
	output logic                               done,
	output logic                               ok,
	output logic [dpsm_pkg::SLOT_W-1:0]        slot,
	output logic                               delivered,
	output logic signed [dpsm_pkg::TIME_W-1:0] out_start,
	output logic signed [dpsm_pkg::TIME_W-1:0] out_stop
);

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int XW = (IW > dpsm_pkg::SLOT_W) ? IW : dpsm_pkg::SLOT_W;
	localparam logic [IW-1:0] LAST_SLOT = IW'(NUM_SLOTS - 1);
	localparam int TW = dpsm_pkg::TIME_W;
	localparam int SW = dpsm_pkg::STAMP_W;

	// Latched command word.
	logic [dpsm_pkg::OP_W-1:0]   op_q;
	logic [dpsm_pkg::SLOT_W-1:0] idx_q;
	logic                        is_ref_q;
	logic                        is_fld_q;
	logic signed [TW-1:0]        st_q;
	logic signed [TW-1:0]        sp_q;

	// Per-slot flags and valid bits for the time and stamp memories.
	logic [NUM_SLOTS-1:0] in_use_q;
	logic [NUM_SLOTS-1:0] ref_q;
	logic [NUM_SLOTS-1:0] disp_q;
	logic [NUM_SLOTS-1:0] time_vld_q;
	logic [NUM_SLOTS-1:0] stamp_vld_q;

	logic [SW-1:0]                next_stamp_q;
	logic [dpsm_pkg::CNT_W-1:0]   wait_cnt_q;
	logic [dpsm_pkg::CNT_W-1:0]   max_wait_q;
	logic                         field_pend_q;

	// Slot memories.
	logic [2*TW-1:0] time_mem [NUM_SLOTS];
	logic [SW-1:0]   stamp_mem [NUM_SLOTS];

	// Scan pipeline.
	logic [IW-1:0]        scan_addr_q;
	logic                 cmp_vld_s1;
	logic [IW-1:0]        cmp_idx_s1;
	logic [2*TW-1:0]      time_rd_s1;
	logic [SW-1:0]        stamp_rd_s1;
	logic                 found_q;
	logic [IW-1:0]        best_pos_q;
	logic [SW-1:0]        best_stamp_q;
	logic signed [TW-1:0] best_start_q;
	logic signed [TW-1:0] best_stop_q;

	logic                 is_alloc;
	logic                 idx_ok;
	logic [XW-1:0]        idx_x;
	logic [IW-1:0]        idx_w;
	logic [XW-1:0]        pos_x;
	logic                 add_commit;
	logic                 time_we;
	logic                 free_en;
	logic [IW-1:0]        free_idx;
	logic [SW-1:0]        cur_stamp;
	logic signed [TW-1:0] cur_start;
	logic signed [TW-1:0] cur_stop;
	logic                 cand;
	logic                 better;
	logic                 take;

	// Command word register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op;
			idx_q    <= surface_index;
			is_ref_q <= is_reference;
			is_fld_q <= is_field;
			st_q     <= start_time;
			sp_q     <= stop_time;
		end
	end

	// Addressing and decode of the latched command.
	assign is_alloc   = (op_q == dpsm_pkg::OP_ALLOC);
	assign idx_ok     = (int'(idx_q) < NUM_SLOTS);
	assign idx_x      = XW'(idx_q);
	assign idx_w      = idx_x[IW-1:0];
	assign pos_x      = XW'(best_pos_q);
	assign add_commit = !(is_fld_q && !field_pend_q);
	assign time_we    = cmd.exec && idx_ok &&
		(((op_q == dpsm_pkg::OP_ADD) && !(is_fld_q && field_pend_q)) ||
		(op_q == dpsm_pkg::OP_UPDATE));

	assign sts.scan_needed = is_alloc ||
		((op_q == dpsm_pkg::OP_DISPLAY) && (wait_cnt_q > max_wait_q));
	assign sts.scan_last   = (scan_addr_q == LAST_SLOT);

	// Freeing a slot: by remove-reference of a displayed slot, or by display
	// of a slot that is not kept as a reference.
	always_comb begin
		free_en  = 1'b0;
		free_idx = idx_w;
		if (cmd.exec && (op_q == dpsm_pkg::OP_REMOVE_REF) && idx_ok && disp_q[idx_w]) begin
			free_en = 1'b1;
		end else if (cmd.finish && (op_q == dpsm_pkg::OP_DISPLAY) && found_q &&
			!ref_q[best_pos_q]) begin
			free_en  = 1'b1;
			free_idx = best_pos_q;
		end
	end

	// Time and stamp memories: one write port, one registered scan read port.
	always_ff @(posedge clk) begin
		if (time_we) begin
			time_mem[idx_w] <= {st_q, sp_q};
		end
		if (free_en) begin
			stamp_mem[free_idx] <= next_stamp_q;
		end
		if (cmd.issue) begin
			time_rd_s1  <= time_mem[scan_addr_q];
			stamp_rd_s1 <= stamp_mem[scan_addr_q];
		end
	end

	// Compare one slot per cycle against the best so far; entries never
	// written since reset or flush read as zero.
	always_comb begin
		cur_stamp = stamp_vld_q[cmp_idx_s1] ? stamp_rd_s1 : '0;
		cur_start = time_vld_q[cmp_idx_s1] ? time_rd_s1[2*TW-1:TW] : '0;
		cur_stop  = time_vld_q[cmp_idx_s1] ? time_rd_s1[TW-1:0] : '0;
		if (is_alloc) begin
			cand   = !in_use_q[cmp_idx_s1];
			better = (cur_stamp < best_stamp_q);
		end else begin
			cand   = in_use_q[cmp_idx_s1] && !disp_q[cmp_idx_s1];
			better = (cur_start < best_start_q);
		end
		take = cmp_vld_s1 && cand && (!found_q || better);
	end

	// Scan address, compare stage and best-candidate registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q <= '0;
			cmp_vld_s1  <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.issue;
			if (cmd.scan_init) begin
				scan_addr_q <= '0;
				found_q     <= 1'b0;
			end else if (cmd.issue) begin
				scan_addr_q <= scan_addr_q + 1'b1;
			end
			if (take) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			cmp_idx_s1 <= scan_addr_q;
		end
		if (take) begin
			best_pos_q   <= cmp_idx_s1;
			best_stamp_q <= cur_stamp;
			best_start_q <= cur_start;
			best_stop_q  <= cur_stop;
		end
	end

	// Slot flags, counters and the threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q     <= '0;
			ref_q        <= '0;
			disp_q       <= '0;
			time_vld_q   <= '0;
			stamp_vld_q  <= '0;
			next_stamp_q <= dpsm_pkg::STAMP_RESET;
			wait_cnt_q   <= '0;
			field_pend_q <= 1'b0;
			max_wait_q   <= dpsm_pkg::MAX_WAIT_RESET;
		end else begin
			if (cfg_write) begin
				max_wait_q <= cfg_data;
			end
			if (time_we) begin
				time_vld_q[idx_w] <= 1'b1;
			end
			if (cmd.exec) begin
				case (op_q)
					dpsm_pkg::OP_ADD: begin
						if (idx_ok) begin
							if (!add_commit) begin
								field_pend_q <= 1'b1;
							end else begin
								ref_q[idx_w]    <= is_ref_q;
								in_use_q[idx_w] <= 1'b1;
								disp_q[idx_w]   <= 1'b0;
								field_pend_q    <= 1'b0;
								if (!in_use_q[idx_w] && (wait_cnt_q != dpsm_pkg::CNT_MAX)) begin
									wait_cnt_q <= wait_cnt_q + 1'b1;
								end
							end
						end
					end
					dpsm_pkg::OP_REMOVE_REF: begin
						if (idx_ok) begin
							ref_q[idx_w] <= 1'b0;
						end
					end
					dpsm_pkg::OP_FLUSH: begin
						in_use_q     <= '0;
						ref_q        <= '0;
						disp_q       <= '0;
						time_vld_q   <= '0;
						stamp_vld_q  <= '0;
						next_stamp_q <= dpsm_pkg::STAMP_RESET;
						wait_cnt_q   <= '0;
						field_pend_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.finish && (op_q == dpsm_pkg::OP_DISPLAY) && found_q) begin
				disp_q[best_pos_q] <= 1'b1;
			end
			// A freed slot takes the next stamp; this overrides the displayed mark.
			if (free_en) begin
				in_use_q[free_idx]    <= 1'b0;
				disp_q[free_idx]      <= 1'b0;
				stamp_vld_q[free_idx] <= 1'b1;
				next_stamp_q          <= next_stamp_q + 1'b1;
				if (wait_cnt_q != '0) begin
					wait_cnt_q <= wait_cnt_q - 1'b1;
				end
			end
		end
	end

	// Result word, shown for one cycle under done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done      <= 1'b0;
			ok        <= 1'b0;
			slot      <= '0;
			delivered <= 1'b0;
			out_start <= '0;
			out_stop  <= '0;
		end else begin
			done <= cmd.exec || cmd.finish;
			if (cmd.exec || cmd.finish) begin
				ok        <= 1'b0;
				slot      <= '0;
				delivered <= 1'b0;
				out_start <= '0;
				out_stop  <= '0;
				if (cmd.exec && (op_q == dpsm_pkg::OP_ADD) && idx_ok && add_commit) begin
					ok <= 1'b1;
				end
				if (cmd.finish && found_q) begin
					ok   <= 1'b1;
					slot <= pos_x[dpsm_pkg::SLOT_W-1:0];
					if (!is_alloc && !best_start_q[TW-1]) begin
						delivered <= 1'b1;
						out_start <= best_start_q;
						out_stop  <= best_stop_q;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int NUM_SLOTS     = 32;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 2 * NUM_SLOTS + 16;
	localparam int PRINT_LIMIT   = 100;

	// Op codes that the block decodes as no operation.
	localparam logic [dpsm_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [dpsm_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

	localparam logic signed [dpsm_pkg::TIME_W-1:0] TIME_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam logic signed [dpsm_pkg::TIME_W-1:0] TIME_MIN = 64'sh8000_0000_0000_0000;

	// One command word as it goes to the block.
	typedef struct packed {
		logic [dpsm_pkg::OP_W-1:0]          op;
		logic [dpsm_pkg::SLOT_W-1:0]        surface_index;
		logic                               is_reference;
		logic                               is_field;
		logic signed [dpsm_pkg::TIME_W-1:0] start_time;
		logic signed [dpsm_pkg::TIME_W-1:0] stop_time;
	} slot_cmd_t;

	// One result word as it comes back.
	typedef struct packed {
		logic                               ok;
		logic [dpsm_pkg::SLOT_W-1:0]        slot;
		logic                               delivered;
		logic signed [dpsm_pkg::TIME_W-1:0] out_start;
		logic signed [dpsm_pkg::TIME_W-1:0] out_stop;
	} slot_result_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               start = 1'b0;
	logic                               busy;
	logic                               cfg_write = 1'b0;
	logic [dpsm_pkg::CNT_W-1:0]         cfg_data = '0;
	logic [dpsm_pkg::OP_W-1:0]          op = '0;
	logic [dpsm_pkg::SLOT_W-1:0]        surface_index = '0;
	logic                               is_reference = 1'b0;
	logic                               is_field = 1'b0;
	logic signed [dpsm_pkg::TIME_W-1:0] start_time = '0;
	logic signed [dpsm_pkg::TIME_W-1:0] stop_time = '0;
	logic                               done;
	logic                               ok;
	logic [dpsm_pkg::SLOT_W-1:0]        slot;
	logic                               delivered;
	logic signed [dpsm_pkg::TIME_W-1:0] out_start;
	logic signed [dpsm_pkg::TIME_W-1:0] out_stop;

	decoded_picture_slot_manager #(
		.NUM_SLOTS(NUM_SLOTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.op(op),
		.surface_index(surface_index),
		.is_reference(is_reference),
		.is_field(is_field),
		.start_time(start_time),
		.stop_time(stop_time),
		.done(done),
		.ok(ok),
		.slot(slot),
		.delivered(delivered),
		.out_start(out_start),
		.out_stop(out_stop)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Shadow copy of the slot table and the threshold register.
	logic                               slot_in_use  [NUM_SLOTS];
	logic                               slot_is_ref  [NUM_SLOTS];
	logic                               slot_shown   [NUM_SLOTS];
	logic signed [dpsm_pkg::TIME_W-1:0] slot_begin   [NUM_SLOTS];
	logic signed [dpsm_pkg::TIME_W-1:0] slot_end     [NUM_SLOTS];
	logic [dpsm_pkg::STAMP_W-1:0]       slot_stamp   [NUM_SLOTS];
	logic [dpsm_pkg::STAMP_W-1:0]       stamp_next;
	logic [dpsm_pkg::CNT_W-1:0]         pictures_waiting;
	logic                               first_field_held;
	logic [dpsm_pkg::CNT_W-1:0]         waiting_limit;

	slot_cmd_t    pending_cmds[$];
	slot_result_t expected_results[$];
	slot_cmd_t    driven_cmd;
	int           hold_off = 0;
	int           no_idle_left = 0;
	int           error_count = 0;
	int           cycle_count = 0;
	int           seq_slot = 0;

	function automatic void clear_slot_table();
		int i;
		for (i = 0; i < NUM_SLOTS; i++) begin
			slot_in_use[i] = 1'b0;
			slot_is_ref[i] = 1'b0;
			slot_shown[i]  = 1'b0;
			slot_begin[i]  = '0;
			slot_end[i]    = '0;
			slot_stamp[i]  = '0;
		end
		stamp_next       = dpsm_pkg::STAMP_RESET;
		pictures_waiting = '0;
		first_field_held = 1'b0;
	endfunction

	// A freed slot takes the next stamp so that allocation goes in free order.
	function automatic void release_slot(input int s);
		slot_stamp[s]  = stamp_next;
		stamp_next     = stamp_next + 1'b1;
		slot_in_use[s] = 1'b0;
		slot_shown[s]  = 1'b0;
		if (pictures_waiting != 0)
			pictures_waiting = pictures_waiting - 1'b1;
	endfunction

	// Apply one command word to the shadow table and return the result it gives.
	function automatic slot_result_t predict_slot_result(input slot_cmd_t c);
		slot_result_t r;
		logic         found;
		logic         was_used;
		int           pos;
		int           idx;
		int           i;
		r     = '0;
		found = 1'b0;
		pos   = 0;
		idx   = int'(c.surface_index);
		case (c.op)
			dpsm_pkg::OP_ALLOC: begin
				for (i = 0; i < NUM_SLOTS; i++) begin
					if (!slot_in_use[i] && (!found || slot_stamp[i] < slot_stamp[pos])) begin
						found = 1'b1;
						pos   = i;
					end
				end
				if (found) begin
					r.ok   = 1'b1;
					r.slot = pos[dpsm_pkg::SLOT_W-1:0];
				end
			end
			dpsm_pkg::OP_ADD: begin
				if (c.is_field && !first_field_held) begin
					// The first field only parks its times in the slot.
					first_field_held = 1'b1;
					slot_begin[idx]  = c.start_time;
					slot_end[idx]    = c.stop_time;
				end else begin
					was_used         = slot_in_use[idx];
					slot_is_ref[idx] = c.is_reference;
					slot_in_use[idx] = 1'b1;
					slot_shown[idx]  = 1'b0;
					if (!c.is_field) begin
						slot_begin[idx] = c.start_time;
						slot_end[idx]   = c.stop_time;
					end
					first_field_held = 1'b0;
					if (!was_used && pictures_waiting < dpsm_pkg::CNT_MAX)
						pictures_waiting = pictures_waiting + 1'b1;
					r.ok = 1'b1;
				end
			end
			dpsm_pkg::OP_UPDATE: begin
				slot_begin[idx] = c.start_time;
				slot_end[idx]   = c.stop_time;
			end
			dpsm_pkg::OP_REMOVE_REF: begin
				slot_is_ref[idx] = 1'b0;
				if (slot_shown[idx])
					release_slot(idx);
			end
			dpsm_pkg::OP_DISPLAY: begin
				if (pictures_waiting > waiting_limit) begin
					for (i = 0; i < NUM_SLOTS; i++) begin
						if (slot_in_use[i] && !slot_shown[i] &&
							(!found || slot_begin[i] < slot_begin[pos])) begin
							found = 1'b1;
							pos   = i;
						end
					end
					if (found) begin
						r.ok   = 1'b1;
						r.slot = pos[dpsm_pkg::SLOT_W-1:0];
						if (slot_begin[pos] >= 0) begin
							r.delivered = 1'b1;
							r.out_start = slot_begin[pos];
							r.out_stop  = slot_end[pos];
						end
						slot_shown[pos] = 1'b1;
						if (!slot_is_ref[pos])
							release_slot(pos);
					end
				end
			end
			dpsm_pkg::OP_FLUSH: begin
				clear_slot_table();
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		error_count++;
		// Keep the log short when something goes badly wrong.
		if (error_count <= PRINT_LIMIT)
			$display("%0t mismatch: %s", $realtime, what);
	endtask

	// Idle cycles before the next command word, with runs of back-to-back words.
	function automatic int draw_hold_off();
		if (no_idle_left > 0) begin
			no_idle_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			no_idle_left = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 14);
	endfunction

	// Driver: a word is accepted at an edge where start is high and busy is low.
	always @(posedge clk) begin : drive_cmds
		logic accepted;
		accepted = arst_n && start && !busy;
		if (accepted) begin
			expected_results.push_back(predict_slot_result(driven_cmd));
			hold_off = draw_hold_off();
		end
		if (arst_n && (!start || accepted)) begin
			if (hold_off > 0) begin
				hold_off--;
				start <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				driven_cmd = pending_cmds.pop_front();
				start         <= 1'b1;
				op            <= driven_cmd.op;
				surface_index <= driven_cmd.surface_index;
				is_reference  <= driven_cmd.is_reference;
				is_field      <= driven_cmd.is_field;
				start_time    <= driven_cmd.start_time;
				stop_time     <= driven_cmd.stop_time;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every result word is compared with the oldest expectation.
	always @(posedge clk) begin : check_results
		slot_result_t got;
		slot_result_t want;
		if (arst_n && done) begin
			got = '{ok, slot, delivered, out_start, out_stop};
			if (expected_results.size() == 0) begin
				report_mismatch("result word with no command waiting for it");
			end else begin
				want = expected_results.pop_front();
				if (got.ok !== want.ok)
					report_mismatch($sformatf("ok %0b, expected %0b", got.ok, want.ok));
				if (got.slot !== want.slot)
					report_mismatch($sformatf("slot %0d, expected %0d", got.slot, want.slot));
				if (got.delivered !== want.delivered)
					report_mismatch($sformatf("delivered %0b, expected %0b",
						got.delivered, want.delivered));
				if (got.out_start !== want.out_start)
					report_mismatch($sformatf("out_start %h, expected %h",
						got.out_start, want.out_start));
				if (got.out_stop !== want.out_stop)
					report_mismatch($sformatf("out_stop %h, expected %h",
						got.out_stop, want.out_stop));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("decoded_picture_slot_manager regression: fail");
			$finish;
		end
	end

	function automatic slot_cmd_t make_cmd(input logic [dpsm_pkg::OP_W-1:0] o,
		input int idx, input logic is_ref, input logic is_fld,
		input logic signed [dpsm_pkg::TIME_W-1:0] st,
		input logic signed [dpsm_pkg::TIME_W-1:0] sp);
		slot_cmd_t c;
		c.op            = o;
		c.surface_index = idx[dpsm_pkg::SLOT_W-1:0];
		c.is_reference  = is_ref;
		c.is_field      = is_fld;
		c.start_time    = st;
		c.stop_time     = sp;
		return c;
	endfunction

	// Mostly small positive times so that ties happen, plus the extremes.
	function automatic logic signed [dpsm_pkg::TIME_W-1:0] random_time();
		case ($urandom_range(0, 11))
			0: return TIME_MAX;
			1: return TIME_MIN;
			2: return -1;
			3: return 0;
			4, 5: return {$urandom, $urandom};
			6: return -$signed({32'd0, $urandom_range(1, 5000)});
			default: return {32'd0, $urandom_range(0, 2000)};
		endcase
	endfunction

	// Noise: any op, any field values, flush kept rare.
	function automatic slot_cmd_t random_cmd();
		logic [dpsm_pkg::OP_W-1:0] o;
		int unsigned               draw;
		draw = $urandom_range(0, 7);
		o    = draw[dpsm_pkg::OP_W-1:0];
		if (o == dpsm_pkg::OP_FLUSH && $urandom_range(0, 3) != 0)
			o = dpsm_pkg::OP_DISPLAY;
		return make_cmd(o, $urandom_range(0, NUM_SLOTS - 1), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), random_time(), random_time());
	endfunction

	// A decoder-like group: allocate, add a frame or a field pair, display,
	// and now and then drop the reference of a recent picture.
	task automatic push_picture_group(inout int count);
		logic is_ref;
		int   n;
		int   i;
		is_ref   = 1'($urandom_range(0, 1));
		seq_slot = (seq_slot + 1) % NUM_SLOTS;
		pending_cmds.push_back(make_cmd(dpsm_pkg::OP_ALLOC, 0, 1'b0, 1'b0, 0, 0));
		count++;
		if ($urandom_range(0, 3) == 0) begin
			for (i = 0; i < 2; i++) begin
				pending_cmds.push_back(make_cmd(dpsm_pkg::OP_ADD, seq_slot, is_ref, 1'b1,
					random_time(), random_time()));
				count++;
			end
		end else begin
			pending_cmds.push_back(make_cmd(dpsm_pkg::OP_ADD, seq_slot, is_ref, 1'b0,
				random_time(), random_time()));
			count++;
		end
		n = $urandom_range(1, 2);
		for (i = 0; i < n; i++) begin
			pending_cmds.push_back(make_cmd(dpsm_pkg::OP_DISPLAY, 0, 1'b0, 1'b0, 0, 0));
			count++;
		end
		if ($urandom_range(0, 2) != 0) begin
			pending_cmds.push_back(make_cmd(dpsm_pkg::OP_REMOVE_REF,
				(seq_slot + NUM_SLOTS - $urandom_range(0, 4)) % NUM_SLOTS,
				1'b0, 1'b0, 0, 0));
			count++;
		end
	endtask

	// Wait until every word is accepted and answered, then let the block settle.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || start || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_waiting_limit(input logic [dpsm_pkg::CNT_W-1:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		waiting_limit = value;
		@(negedge clk);
	endtask

	task automatic run_random_phase(input logic [dpsm_pkg::CNT_W-1:0] limit,
		input int target);
		int count;
		count = 0;
		write_waiting_limit(limit);
		while (count < target) begin
			if ($urandom_range(0, 9) < 7) begin
				push_picture_group(count);
			end else begin
				pending_cmds.push_back(random_cmd());
				count++;
			end
		end
		wait_idle();
	endtask

	// Stimulus and end of run.
	initial begin : stimulus
		int          i;
		int unsigned draw;
		clear_slot_table();
		waiting_limit = dpsm_pkg::MAX_WAIT_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part with the reset threshold of two.
		pending_cmds.push_back(make_cmd(dpsm_pkg::OP_ALLOC, 0, 1'b0, 1'b0, 0, 0));
		pending_cmds.push_back(make_cmd(dpsm_pkg::OP_DISPLAY, 0, 1'b0, 1'b0, 0, 0));
		pending_cmds.push_back(make_cmd(dpsm_pkg::OP_ADD, 0, 1'b1, 1'b0, TIME_MAX, TIME_MIN));
		pending_cmds.push_back(make_cmd(dpsm_pkg::OP_ADD, NUM_SLOTS - 1, 1'b0, 1'b0, -1,
			TIME_MAX));
		pending_cmds.push_back(make_cmd(dpsm_pkg::OP_ADD, 2, 1'b0, 1'b0, 0, 0));
		// A field pair: the second field keeps the times of the first.
		pending_cmds.push_back(make_cmd(dpsm_pkg::OP_ADD, 3, 1'b1, 1'b1, 5, 6));
		pending_cmds.push_back(make_cmd(dpsm_pkg::OP_ADD, 3, 1'b1, 1'b1, 99, 100));
		// Negative start is picked but not delivered, then zero is delivered.
		pending_cmds.push_back(make_cmd(dpsm_pkg::OP_DISPLAY, 0, 1'b0, 1'b0, 0, 0));
		pending_cmds.push_back(make_cmd(dpsm_pkg::OP_DISPLAY, 0, 1'b0, 1'b0, 0, 0));
		pending_cmds.push_back(make_cmd(dpsm_pkg::OP_DISPLAY, 0, 1'b0, 1'b0, 0, 0));
		pending_cmds.push_back(make_cmd(dpsm_pkg::OP_ALLOC, 0, 1'b0, 1'b0, 0, 0));
		pending_cmds.push_back(make_cmd(dpsm_pkg::OP_UPDATE, 4, 1'b0, 1'b0, 7, 8));
		pending_cmds.push_back(make_cmd(dpsm_pkg::OP_ADD, 0, 1'b1, 1'b0, 12, 13));
		pending_cmds.push_back(make_cmd(OP_SPARE_6, NUM_SLOTS - 1, 1'b1, 1'b1, -1, -1));
		pending_cmds.push_back(make_cmd(OP_SPARE_7, NUM_SLOTS - 1, 1'b1, 1'b1, -1, -1));
		pending_cmds.push_back(make_cmd(dpsm_pkg::OP_REMOVE_REF, 0, 1'b0, 1'b0, 0, 0));
		pending_cmds.push_back(make_cmd(dpsm_pkg::OP_FLUSH, 0, 1'b0, 1'b0, 0, 0));
		wait_idle();

		// Threshold zero: ties, reference release and the largest start.
		write_waiting_limit('0);
		pending_cmds.push_back(make_cmd(dpsm_pkg::OP_ADD, 5, 1'b1, 1'b0, 10, 11));
		pending_cmds.push_back(make_cmd(dpsm_pkg::OP_ADD, 6, 1'b0, 1'b0, 10, 12));
		pending_cmds.push_back(make_cmd(dpsm_pkg::OP_DISPLAY, 0, 1'b0, 1'b0, 0, 0));
		pending_cmds.push_back(make_cmd(dpsm_pkg::OP_REMOVE_REF, 5, 1'b0, 1'b0, 0, 0));
		pending_cmds.push_back(make_cmd(dpsm_pkg::OP_DISPLAY, 0, 1'b0, 1'b0, 0, 0));
		pending_cmds.push_back(make_cmd(dpsm_pkg::OP_ADD, 7, 1'b0, 1'b0, TIME_MAX, TIME_MAX));
		pending_cmds.push_back(make_cmd(dpsm_pkg::OP_DISPLAY, 0, 1'b0, 1'b0, 0, 0));
		pending_cmds.push_back(make_cmd(dpsm_pkg::OP_ALLOC, 0, 1'b0, 1'b0, 0, 0));
		wait_idle();

		// Threshold of 32: fill the whole table so allocate finds nothing.
		write_waiting_limit(6'd32);
		pending_cmds.push_back(make_cmd(dpsm_pkg::OP_FLUSH, 0, 1'b0, 1'b0, 0, 0));
		for (i = 0; i < NUM_SLOTS; i++)
			pending_cmds.push_back(make_cmd(dpsm_pkg::OP_ADD, i, 1'($urandom_range(0, 1)),
				1'b0, random_time(), random_time()));
		pending_cmds.push_back(make_cmd(dpsm_pkg::OP_ALLOC, 0, 1'b0, 1'b0, 0, 0));
		pending_cmds.push_back(make_cmd(dpsm_pkg::OP_DISPLAY, 0, 1'b0, 1'b0, 0, 0));
		wait_idle();

		// Random phases across several thresholds, extremes included.
		run_random_phase(6'd32, 220);
		run_random_phase(6'd0, 220);
		run_random_phase(6'd1, 220);
		run_random_phase(6'd31, 220);
		run_random_phase(dpsm_pkg::MAX_WAIT_RESET, 220);
		draw = $urandom_range(0, 32);
		run_random_phase(draw[dpsm_pkg::CNT_W-1:0], 220);
		draw = $urandom_range(0, 8);
		run_random_phase(draw[dpsm_pkg::CNT_W-1:0], 220);
		run_random_phase(6'd0, 210);

		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d result words never arrived",
				expected_results.size()));
		if (error_count == 0) begin
			$display("decoded_picture_slot_manager regression: pass");
		end else begin
			$display("decoded_picture_slot_manager regression: fail");
		end
		$finish;
	end

endmodule
